FILE: design/bounded_array_deque_unit_macros.svh
// ----------------------------------------------------------------------------
// Bounded array deque assertion macros
// Shared concurrent assertion forms for the deque RTL.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_ARRAY_DEQUE_UNIT_MACROS_SVH
`define BOUNDED_ARRAY_DEQUE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BDQ_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BDQ_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/bdq_pkg.sv
// ----------------------------------------------------------------------------
// Bounded array deque package
// Sizes, request and status codes, and types shared by the deque modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bdq_pkg;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned ENTRY_WIDTH = 32;
  localparam int unsigned SLOT_W      = $clog2(DEPTH);
  localparam int unsigned CNT_W       = $clog2(DEPTH + 1);

  // Field widths of the request and response transfers.
  localparam int unsigned REQ_W    = 3;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  typedef logic [ENTRY_WIDTH-1:0] entry_t;
  typedef logic [SLOT_W-1:0]      slot_t;
  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [VALUE_W-1:0]     value_t;
  typedef logic [POS_W-1:0]       pos_t;
  typedef logic [COUNT_W-1:0]     count_t;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_READ_POS   = 3'd4,
    REQ_READ_FRONT = 3'd5,
    REQ_READ_BACK  = 3'd6
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Per-cell command: shift takes the lower neighbour's entry, load takes the item.
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

  typedef struct packed {
    status_e status;
    logic    has_value;
    cnt_t    count;
  } result_t;

endpackage

`default_nettype wire

FILE: design/bdq_req_if.sv
// ----------------------------------------------------------------------------
// Deque request channel
// Valid/ready channel carrying one request per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface bdq_req_if;
  logic                           valid;
  logic                           ready;
  logic [bdq_pkg::REQ_W-1:0]      req_type;
  logic [bdq_pkg::VALUE_W-1:0]    item_value;
  logic [bdq_pkg::POS_W-1:0]      position;

  modport source (output valid, output req_type, output item_value, output position,
                  input ready);
  modport sink   (input valid, input req_type, input item_value, input position,
                  output ready);
endinterface

`default_nettype wire

FILE: design/bdq_rsp_if.sv
// ----------------------------------------------------------------------------
// Deque response channel
// Valid/ready channel carrying one result per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface bdq_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [bdq_pkg::VALUE_W-1:0]    read_value;
  logic [bdq_pkg::STATUS_W-1:0]   status;
  logic [bdq_pkg::COUNT_W-1:0]    count;

  modport source (output valid, output read_value, output status, output count,
                  input ready);
  modport sink   (input valid, input read_value, input status, input count,
                  output ready);
endinterface

`default_nettype wire

FILE: design/bdq_cell.sv
// ----------------------------------------------------------------------------
// Deque storage cell
// Holds one entry; shifts in its lower neighbour's entry or loads a new item.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_cell (
  input  wire                  clk_i,
  input  bdq_pkg::cell_ctrl_t  ctrl_i,
  input  bdq_pkg::entry_t      shift_in_i,
  input  bdq_pkg::entry_t      item_i,
  output bdq_pkg::entry_t      entry_o
);

  bdq_pkg::entry_t entry_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      entry_q <= shift_in_i;
    end else if (ctrl_i.load) begin
      entry_q <= item_i;
    end
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

FILE: design/bdq_ctrl.sv
// ----------------------------------------------------------------------------
// Deque pointer control
// Keeps front, back and count, decodes requests into cell commands and results.
// ----------------------------------------------------------------------------
`default_nettype none
`include "bounded_array_deque_unit_macros.svh"

module bdq_ctrl (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          req_valid_i,
  input  wire [bdq_pkg::REQ_W-1:0]     req_type_i,
  input  bdq_pkg::pos_t                position_i,
  output bdq_pkg::cell_ctrl_t          cell_ctrl_o [bdq_pkg::DEPTH],
  output bdq_pkg::slot_t               rd_idx_o,
  output bdq_pkg::result_t             result_o
);

  localparam int unsigned CmpW = (bdq_pkg::CNT_W > bdq_pkg::POS_W) ?
                                 bdq_pkg::CNT_W : bdq_pkg::POS_W;

  bdq_pkg::slot_t front_q, front_d;
  bdq_pkg::slot_t back_q, back_d;
  bdq_pkg::cnt_t  count_q, count_d;

  logic            last_slot;
  logic            empty;
  logic            pos_ok;
  logic            shift_en;
  logic            load_en;
  bdq_pkg::slot_t  load_idx;
  bdq_pkg::cnt_t   count_dec;
  bdq_pkg::req_e   op;

  always_comb begin
    op        = bdq_pkg::req_e'(req_type_i);
    last_slot = (back_q == bdq_pkg::slot_t'(bdq_pkg::DEPTH - 1));
    empty     = (count_q == '0);
    pos_ok    = (CmpW'(position_i) < CmpW'(count_q));
    count_dec = count_q - bdq_pkg::cnt_t'(1);

    front_d   = front_q;
    back_d    = back_q;
    count_d   = count_q;
    shift_en  = 1'b0;
    load_en   = 1'b0;
    load_idx  = '0;
    rd_idx_o  = front_q;
    result_o.status    = bdq_pkg::ST_OK;
    result_o.has_value = 1'b0;

    if (req_valid_i) begin
      case (op)
        bdq_pkg::REQ_PUSH_FRONT: begin
          if (empty) begin
            front_d = '0;
            back_d  = '0;
            load_en = 1'b1;
            count_d = bdq_pkg::cnt_t'(1);
          end else if (front_q == '0) begin
            if (last_slot) begin
              result_o.status = bdq_pkg::ST_FULL;
            end else begin
              // Every cell moves up one slot; cell zero takes the new item.
              shift_en = 1'b1;
              back_d   = back_q + bdq_pkg::slot_t'(1);
              count_d  = count_q + bdq_pkg::cnt_t'(1);
            end
          end else begin
            front_d  = front_q - bdq_pkg::slot_t'(1);
            load_en  = 1'b1;
            load_idx = front_q - bdq_pkg::slot_t'(1);
            count_d  = count_q + bdq_pkg::cnt_t'(1);
          end
        end
        bdq_pkg::REQ_PUSH_BACK: begin
          if (empty) begin
            front_d = '0;
            back_d  = '0;
            load_en = 1'b1;
            count_d = bdq_pkg::cnt_t'(1);
          end else if (last_slot) begin
            result_o.status = bdq_pkg::ST_FULL;
          end else begin
            back_d   = back_q + bdq_pkg::slot_t'(1);
            load_en  = 1'b1;
            load_idx = back_q + bdq_pkg::slot_t'(1);
            count_d  = count_q + bdq_pkg::cnt_t'(1);
          end
        end
        bdq_pkg::REQ_POP_FRONT: begin
          if (empty) begin
            result_o.status = bdq_pkg::ST_EMPTY;
          end else begin
            result_o.has_value = 1'b1;
            rd_idx_o = front_q;
            count_d  = count_dec;
            if (count_dec == '0) begin
              front_d = '0;
              back_d  = '0;
            end else begin
              front_d = front_q + bdq_pkg::slot_t'(1);
            end
          end
        end
        bdq_pkg::REQ_POP_BACK: begin
          if (empty) begin
            result_o.status = bdq_pkg::ST_EMPTY;
          end else begin
            result_o.has_value = 1'b1;
            rd_idx_o = back_q;
            count_d  = count_dec;
            if (count_dec == '0) begin
              front_d = '0;
              back_d  = '0;
            end else if (back_q != '0) begin
              back_d = back_q - bdq_pkg::slot_t'(1);
            end
          end
        end
        bdq_pkg::REQ_READ_POS: begin
          if (!pos_ok) begin
            result_o.status = bdq_pkg::ST_EMPTY;
          end else begin
            result_o.has_value = 1'b1;
            rd_idx_o = front_q + bdq_pkg::slot_t'(position_i);
          end
        end
        bdq_pkg::REQ_READ_FRONT: begin
          if (empty) begin
            result_o.status = bdq_pkg::ST_EMPTY;
          end else begin
            result_o.has_value = 1'b1;
            rd_idx_o = front_q;
          end
        end
        bdq_pkg::REQ_READ_BACK: begin
          if (empty) begin
            result_o.status = bdq_pkg::ST_EMPTY;
          end else begin
            result_o.has_value = 1'b1;
            rd_idx_o = back_q;
          end
        end
        default: begin
          // The unused request code leaves everything unchanged.
        end
      endcase
    end

    result_o.count = count_d;

    for (int i = 0; i < int'(bdq_pkg::DEPTH); i++) begin
      cell_ctrl_o[i].shift = shift_en;
      cell_ctrl_o[i].load  = load_en && (bdq_pkg::slot_t'(i) == load_idx);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      back_q  <= '0;
      count_q <= '0;
    end else if (req_valid_i) begin
      front_q <= front_d;
      back_q  <= back_d;
      count_q <= count_d;
    end
  end

  `BDQ_ASSERT_IMP(a_empty_at_home, clk_i, rst_ni, count_q == '0, (front_q == '0) && (back_q == '0), "empty deque has pointers away from slot zero")
  `BDQ_ASSERT_IMP(a_span_matches_count, clk_i, rst_ni, count_q != '0, (bdq_pkg::cnt_t'(back_q) - bdq_pkg::cnt_t'(front_q) + bdq_pkg::cnt_t'(1)) == count_q, "live span disagrees with count")
  `BDQ_ASSERT_NXT(a_full_no_change, clk_i, rst_ni, req_valid_i && (result_o.status == bdq_pkg::ST_FULL), $stable(count_q) && $stable(back_q) && $stable(front_q), "failed push changed the pointers")

endmodule

`default_nettype wire

FILE: design/bounded_array_deque_unit.sv
// Latency: a result is presented in the cycle after its request transfer.
// Throughput: one request per cycle while rsp.ready holds; the output register lets a new request
// transfer in the same cycle that the waiting result transfers out.
// A push front with the front at slot zero shifts every cell at the edge that takes the request.
// Reset clears the front, back, count and output valid; entries are not cleared.
// ----------------------------------------------------------------------------
// Bounded array deque unit
// A deque held in a row of storage cells, with a registered response channel.
// ----------------------------------------------------------------------------
`default_nettype none
`include "bounded_array_deque_unit_macros.svh"

module bounded_array_deque_unit (
  input  wire         clk_i,
  input  wire         rst_ni,
  bdq_req_if.sink     req,
  bdq_rsp_if.source   rsp
);

  // Each cell holds one slot of the store. On a front shift every cell takes
  // the entry of the cell below it, and cell zero takes the pushed item.
  bdq_pkg::entry_t      entry_w    [bdq_pkg::DEPTH];
  bdq_pkg::entry_t      shift_in_w [bdq_pkg::DEPTH];
  bdq_pkg::cell_ctrl_t  cell_ctrl_w [bdq_pkg::DEPTH];
  bdq_pkg::entry_t      item_w;
  bdq_pkg::slot_t       rd_idx_w;
  bdq_pkg::result_t     result_w;
  logic                 accept_w;

  logic                 rsp_valid_q;
  bdq_pkg::value_t      read_value_q;
  bdq_pkg::status_e     status_q;
  bdq_pkg::count_t      count_q;

  // A request transfers whenever the output register is empty or is being
  // emptied in the same cycle.
  assign req.ready = !rsp_valid_q || rsp.ready;
  assign accept_w  = req.valid && req.ready;
  assign item_w    = bdq_pkg::entry_t'(req.item_value);

  bdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (accept_w),
    .req_type_i  (req.req_type),
    .position_i  (req.position),
    .cell_ctrl_o (cell_ctrl_w),
    .rd_idx_o    (rd_idx_w),
    .result_o    (result_w)
  );

  for (genvar g = 0; g < int'(bdq_pkg::DEPTH); g++) begin : g_cell
    if (g == 0) begin : g_first
      assign shift_in_w[g] = item_w;
    end else begin : g_rest
      assign shift_in_w[g] = entry_w[g-1];
    end

    bdq_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (cell_ctrl_w[g]),
      .shift_in_i (shift_in_w[g]),
      .item_i     (item_w),
      .entry_o    (entry_w[g])
    );
  end

  // Output register. The read data comes from the cells before this
  // request's own update, which lands at the same edge.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (accept_w) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_w) begin
      read_value_q <= result_w.has_value ? bdq_pkg::value_t'(entry_w[rd_idx_w]) : '0;
      status_q     <= result_w.status;
      count_q      <= bdq_pkg::count_t'(result_w.count);
    end
  end

  assign rsp.valid      = rsp_valid_q;
  assign rsp.read_value = read_value_q;
  assign rsp.status     = status_q;
  assign rsp.count      = count_q;

  `BDQ_ASSERT_NXT(a_accept_gives_result, clk_i, rst_ni, accept_w, rsp_valid_q, "transferred request left no result")
  `BDQ_ASSERT_IMP(a_ready_when_free, clk_i, rst_ni, !rsp_valid_q, req.ready, "request channel blocked with no result waiting")
  `BDQ_ASSERT_NXT(a_rsp_held, clk_i, rst_ni, rsp_valid_q && !rsp.ready, rsp_valid_q && $stable(read_value_q) && $stable(status_q) && $stable(count_q), "waiting result changed before its transfer")

endmodule

`default_nettype wire
